/* rtl/core/pvp_pkg.sv */
// Package for the perspective vertex projector: register indexes, constants
// and fixed-point helper widths. No dependencies.
`timescale 1ns / 1ps
package pvp_pkg;

  localparam logic [2:0] REG_ROT_Z  = 3'd0;
  localparam logic [2:0] REG_ROT_X  = 3'd1;
  localparam logic [2:0] REG_FOV    = 3'd2;
  localparam logic [2:0] REG_ORG_X  = 3'd3;
  localparam logic [2:0] REG_ORG_Y  = 3'd4;
  localparam logic [2:0] REG_OFS_X  = 3'd5;
  localparam logic [2:0] REG_OFS_Y  = 3'd6;

  localparam logic signed [31:0] CAMERA_DISTANCE = 32'sd29491200;

  // One quotient bit a stage: |coord*fov| < 2^63, depth >= 1
  localparam int DIV_STEPS = 64;

  typedef struct packed {
    logic signed [15:0] ofs_x;
    logic signed [15:0] ofs_y;
    logic [30:0]        org_x;
    logic [30:0]        org_y;
    logic [31:0]        depth;
    logic               behind;
  } side_t;

  function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
    if (v > 48'sh0000_7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (v < -48'sh0000_8000_0000) return 32'sh8000_0000;
    return v[31:0];
  endfunction

endpackage

/* rtl/core/pvp_div_pipe.sv */
// Pipelined unsigned restoring divider, one quotient bit per stage.
// Depends on pvp_pkg. Carries a side-band record and a valid bit per stage.
`timescale 1ns / 1ps
module pvp_div_pipe (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  input  logic [63:0]            num_x_i,
  input  logic [63:0]            num_y_i,
  input  logic [31:0]            den_i,
  input  logic                   neg_x_i,
  input  logic                   neg_y_i,
  input  pvp_pkg::side_t         side_i,
  output logic                   valid_o,
  output logic [63:0]            quo_x_o,
  output logic [63:0]            quo_y_o,
  output logic                   neg_x_o,
  output logic                   neg_y_o,
  output pvp_pkg::side_t         side_o
);
  import pvp_pkg::*;

  logic                      v_q  [DIV_STEPS];
  logic [63:0]               nx_q [DIV_STEPS];
  logic [63:0]               ny_q [DIV_STEPS];
  logic [31:0]               rx_q [DIV_STEPS];
  logic [31:0]               ry_q [DIV_STEPS];
  logic [31:0]               d_q  [DIV_STEPS];
  logic                      sx_q [DIV_STEPS];
  logic                      sy_q [DIV_STEPS];
  side_t                     sd_q [DIV_STEPS];

  for (genvar g = 0; g < DIV_STEPS; g++) begin : g_step
    logic        v_in;
    logic [63:0] nx_in, ny_in;
    logic [31:0] rx_in, ry_in, d_in;
    logic        sx_in, sy_in;
    side_t       sd_in;
    logic [32:0] tx, ty;
    logic [33:0] dfx, dfy;

    if (g == 0) begin : g_head
      assign v_in  = valid_i;
      assign nx_in = num_x_i;
      assign ny_in = num_y_i;
      assign rx_in = '0;
      assign ry_in = '0;
      assign d_in  = den_i;
      assign sx_in = neg_x_i;
      assign sy_in = neg_y_i;
      assign sd_in = side_i;
    end else begin : g_body
      assign v_in  = v_q[g-1];
      assign nx_in = nx_q[g-1];
      assign ny_in = ny_q[g-1];
      assign rx_in = rx_q[g-1];
      assign ry_in = ry_q[g-1];
      assign d_in  = d_q[g-1];
      assign sx_in = sx_q[g-1];
      assign sy_in = sy_q[g-1];
      assign sd_in = sd_q[g-1];
    end

    assign tx  = {rx_in, nx_in[63]};
    assign ty  = {ry_in, ny_in[63]};
    assign dfx = {1'b0, tx} - {2'b0, d_in};
    assign dfy = {1'b0, ty} - {2'b0, d_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[g] <= 1'b0;
      end else begin
        v_q[g] <= v_in;
      end
    end

    // Shift the numerator left; its low end collects quotient bits.
    always_ff @(posedge clk_i) begin
      rx_q[g] <= dfx[33] ? tx[31:0] : dfx[31:0];
      ry_q[g] <= dfy[33] ? ty[31:0] : dfy[31:0];
      nx_q[g] <= {nx_in[62:0], ~dfx[33]};
      ny_q[g] <= {ny_in[62:0], ~dfy[33]};
      d_q[g]  <= d_in;
      sx_q[g] <= sx_in;
      sy_q[g] <= sy_in;
      sd_q[g] <= sd_in;
    end
  end

  assign valid_o = v_q[DIV_STEPS-1];
  assign quo_x_o = nx_q[DIV_STEPS-1];
  assign quo_y_o = ny_q[DIV_STEPS-1];
  assign neg_x_o = sx_q[DIV_STEPS-1];
  assign neg_y_o = sy_q[DIV_STEPS-1];
  assign side_o  = sd_q[DIV_STEPS-1];

endmodule

/* rtl/core/perspective_vertex_projector_core.sv */
// Perspective vertex projector top level: rotation, depth, pipelined divide,
// origin and offset. Depends on pvp_pkg and pvp_div_pipe.
// Pipeline: 71 register stages (six arithmetic, 64 divider, one output); done_o
// is registered from the divider valid, in step with the registered result.
// Throughput one vertex per cycle; busy is never raised. Reset clears all
// valid bits and restores register defaults; the receiver cannot stall.
`timescale 1ns / 1ps
module perspective_vertex_projector_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] vx_i,
  input  logic signed [31:0] vy_i,
  input  logic signed [31:0] vz_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  output logic               done_o,
  output logic signed [15:0] pix_x_o,
  output logic signed [15:0] pix_y_o,
  output logic signed [31:0] depth_o,
  output logic               behind_camera_o
);
  import pvp_pkg::*;

  // ---------------------------------------------------------------- config
  logic [31:0] rot_z_q, rot_x_q, fov_q;
  logic [30:0] org_x_q, org_y_q;
  logic [15:0] ofs_x_q, ofs_y_q;

  assign cfg_ready_o = 1'b1;
  assign busy        = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_z_q <= 32'd16384;
      rot_x_q <= 32'd16384;
      fov_q   <= 32'd65536;
      org_x_q <= '0;
      org_y_q <= '0;
      ofs_x_q <= '0;
      ofs_y_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_ROT_Z: rot_z_q <= cfg_data_i;
        REG_ROT_X: rot_x_q <= cfg_data_i;
        REG_FOV:   fov_q   <= cfg_data_i;
        REG_ORG_X: org_x_q <= cfg_data_i[30:0];
        REG_ORG_Y: org_y_q <= cfg_data_i[30:0];
        REG_OFS_X: ofs_x_q <= cfg_data_i[15:0];
        REG_OFS_Y: ofs_y_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  logic signed [15:0] cz, sz, cx, sx;
  assign cz = rot_z_q[15:0];
  assign sz = rot_z_q[31:16];
  assign cx = rot_x_q[15:0];
  assign sx = rot_x_q[31:16];

  // -------------------------------------------------- stage 1: Z products
  logic [5:0] v_q;
  logic signed [47:0] p_xc_q, p_ys_q, p_xs_q, p_yc_q;
  logic signed [31:0] vz1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_q <= '0;
    else         v_q <= {v_q[4:0], start && !busy};
  end

  always_ff @(posedge clk_i) begin
    p_xc_q <= 48'(vx_i) * 48'(cz);
    p_ys_q <= 48'(vy_i) * 48'(sz);
    p_xs_q <= 48'(vx_i) * 48'(sz);
    p_yc_q <= 48'(vy_i) * 48'(cz);
    vz1_q  <= vz_i;
  end

  // --------------------------------------------- stage 2: Z rotate, floor
  logic signed [48:0] rx_full, ry_full;
  logic signed [31:0] rx2_q, vz2_q;
  logic signed [34:0] ry2_q;  // |ry| <= 2^33
  assign rx_full = 49'(p_xc_q) - 49'(p_ys_q);
  assign ry_full = 49'(p_xs_q) + 49'(p_yc_q);

  always_ff @(posedge clk_i) begin
    rx2_q <= sat32(48'(rx_full >>> 14));
    ry2_q <= 35'(ry_full >>> 14);
    vz2_q <= vz1_q;
  end

  // -------------------------------------------------- stage 3: X products
  logic signed [50:0] p_rc_q, p_rs_q;
  logic signed [47:0] p_zs_q, p_zc_q;
  logic signed [31:0] rx3_q;

  always_ff @(posedge clk_i) begin
    p_rc_q <= 51'(ry2_q) * 51'(cx);
    p_rs_q <= 51'(ry2_q) * 51'(sx);
    p_zs_q <= 48'(vz2_q) * 48'(sx);
    p_zc_q <= 48'(vz2_q) * 48'(cx);
    rx3_q  <= rx2_q;
  end

  // ---------------------------------------------- stage 4: X rotate, depth
  logic signed [51:0] fy_full, fz_full;
  logic signed [37:0] fy_sh, fz_sh;
  logic signed [31:0] fy4_q, fz4_q, rx4_q;
  assign fy_full = 52'(p_rc_q) + 52'(p_zs_q);
  assign fz_full = 52'(p_rs_q) - 52'(p_zc_q);
  assign fy_sh   = 38'(fy_full >>> 14);
  assign fz_sh   = 38'(fz_full >>> 14) + 38'(CAMERA_DISTANCE);

  function automatic logic signed [31:0] sat38(input logic signed [37:0] v);
    if (v > 38'sh0_7FFF_FFFF)  return 32'sh7FFF_FFFF;
    if (v < -38'sh0_8000_0000) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  always_ff @(posedge clk_i) begin
    fy4_q <= sat38(fy_sh);
    fz4_q <= sat38(fz_sh);
    rx4_q <= rx3_q;
  end

  // --------------------------------------------- stage 5: fov products
  logic signed [63:0] nx5_q, ny5_q;
  logic signed [31:0] fz5_q;

  always_ff @(posedge clk_i) begin
    nx5_q <= 64'(rx4_q) * 64'($signed({1'b0, fov_q}));
    ny5_q <= 64'(fy4_q) * 64'($signed({1'b0, fov_q}));
    fz5_q <= fz4_q;
  end

  // --------------------------------------------- stage 6: magnitudes
  logic [63:0] mx6_q, my6_q;
  logic        nx6_q, ny6_q;
  side_t       sd6_q;

  always_ff @(posedge clk_i) begin
    mx6_q <= nx5_q[63] ? 64'(-nx5_q) : nx5_q;
    my6_q <= ny5_q[63] ? 64'(-ny5_q) : ny5_q;
    nx6_q <= nx5_q[63];
    ny6_q <= ny5_q[63];
    sd6_q <= '{ofs_x: ofs_x_q, ofs_y: ofs_y_q, org_x: org_x_q, org_y: org_y_q,
               depth: fz5_q, behind: (fz5_q <= 0)};
  end

  // ---------------------------------------------------- divider pipeline
  logic        dv;
  logic [63:0] qx, qy;
  logic        dnx, dny;
  side_t       dsd;

  pvp_div_pipe u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v_q[5]),
    .num_x_i (mx6_q),
    .num_y_i (my6_q),
    .den_i   (sd6_q.behind ? 32'd1 : sd6_q.depth),
    .neg_x_i (nx6_q),
    .neg_y_i (ny6_q),
    .side_i  (sd6_q),
    .valid_o (dv),
    .quo_x_o (qx),
    .quo_y_o (qy),
    .neg_x_o (dnx),
    .neg_y_o (dny),
    .side_o  (dsd)
  );

  // ------------------------------------ stage 7: sign, origin, truncate
  // Quotient magnitude below 2^63 (numerator < 2^63), so sign fits 64 bits.
  logic signed [64:0] px, py, sumx, sumy;
  logic signed [64:0] ix, iy;
  logic signed [65:0] tx, ty;
  assign px   = dnx ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
  assign py   = dny ? -$signed({1'b0, qy}) : $signed({1'b0, qy});
  assign sumx = px + 65'(dsd.org_x);
  assign sumy = py + 65'(dsd.org_y);
  // Truncate toward zero: bias negatives by 2^16-1 before the shift.
  assign ix   = (sumx + (sumx[64] ? 65'sd65535 : 65'sd0)) >>> 16;
  assign iy   = (sumy + (sumy[64] ? 65'sd65535 : 65'sd0)) >>> 16;
  assign tx   = 66'(ix) + 66'(dsd.ofs_x);
  assign ty   = 66'(iy) + 66'(dsd.ofs_y);

  function automatic logic signed [15:0] sat16(input logic signed [65:0] v);
    if (v > 66'sd32767)  return 16'sh7FFF;
    if (v < -66'sd32768) return 16'sh8000;
    return v[15:0];
  endfunction

  logic done_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_q <= 1'b0;
    else         done_q <= dv;
  end

  always_ff @(posedge clk_i) begin
    pix_x_o         <= dsd.behind ? 16'sd0 : sat16(tx);
    pix_y_o         <= dsd.behind ? 16'sd0 : sat16(ty);
    depth_o         <= dsd.depth;
    behind_camera_o <= dsd.behind;
  end

  assign done_o = done_q;

  // ------------------------------------------------------------ checks
  a_behind_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && behind_camera_o |-> pix_x_o == 16'sd0 && pix_y_o == 16'sd0)
    else $error("behind-camera result carries non-zero screen coordinates");

  a_behind_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> behind_camera_o == ($signed(depth_o) <= 0))
    else $error("behind flag disagrees with depth");

  a_stage_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[5] |=> ##63 dv)
    else $error("request lost in divider pipeline");

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for perspective_vertex_projector_core: drives vertex
// requests and register writes, predicts each projected vertex and checks it.
// Depends on pvp_pkg and the core RTL.
`timescale 1ns / 1ps

class projection_scoreboard;
  // shadow registers
  logic [31:0] rot_z, rot_x, fov;
  logic [30:0] org_x, org_y;
  logic signed [15:0] ofs_x, ofs_y;
  typedef struct {
    logic signed [15:0] sx;
    logic signed [15:0] sy;
    logic signed [31:0] depth;
    logic               behind;
  } projection_t;
  projection_t pending[$];
  int errors;

  function new();
    reset_regs();
    errors = 0;
  endfunction

  function void reset_regs();
    rot_z = 32'h4000; rot_x = 32'h4000; fov = 32'h10000;
    org_x = '0; org_y = '0; ofs_x = '0; ofs_y = '0;
  endfunction

  function void write_reg(logic [2:0] idx, logic [31:0] data);
    case (idx)
      pvp_pkg::REG_ROT_Z: rot_z = data;
      pvp_pkg::REG_ROT_X: rot_x = data;
      pvp_pkg::REG_FOV:   fov = data;
      pvp_pkg::REG_ORG_X: org_x = data[30:0];
      pvp_pkg::REG_ORG_Y: org_y = data[30:0];
      pvp_pkg::REG_OFS_X: ofs_x = data[15:0];
      pvp_pkg::REG_OFS_Y: ofs_y = data[15:0];
      default: ;
    endcase
  endfunction

  // arithmetic shift right is floor division by a power of two
  function automatic longint clamp(longint v, longint lo, longint hi);
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic longint to_pixel(longint c, longint d, logic [30:0] org,
                                      logic signed [15:0] ofs);
    longint p, s;
    p = (c * longint'({32'd0, fov})) / d;
    s = (p + longint'({33'd0, org})) / 65536;
    return clamp(s + longint'(ofs), -32768, 32767);
  endfunction

  function void note_vertex(logic signed [31:0] vx, logic signed [31:0] vy,
                            logic signed [31:0] vz);
    longint cz, sz, cx, sx, rx, ry, fy, fz;
    projection_t e;
    cz = longint'($signed(rot_z[15:0])); sz = longint'($signed(rot_z[31:16]));
    cx = longint'($signed(rot_x[15:0])); sx = longint'($signed(rot_x[31:16]));
    rx = clamp((longint'(vx) * cz - longint'(vy) * sz) >>> 14, -(64'sd1 <<< 31),
               (64'sd1 <<< 31) - 1);
    ry = (longint'(vx) * sz + longint'(vy) * cz) >>> 14;
    fy = clamp((ry * cx + longint'(vz) * sx) >>> 14, -(64'sd1 <<< 31),
               (64'sd1 <<< 31) - 1);
    fz = clamp(((ry * sx - longint'(vz) * cx) >>> 14) + 29491200,
               -(64'sd1 <<< 31), (64'sd1 <<< 31) - 1);
    e.depth = fz[31:0];
    e.behind = (fz <= 0);
    e.sx = '0; e.sy = '0;
    if (!e.behind) begin
      e.sx = 16'(to_pixel(rx, fz, org_x, ofs_x));
      e.sy = 16'(to_pixel(fy, fz, org_y, ofs_y));
    end
    pending.push_back(e);
  endfunction

  function void check_projection(logic signed [15:0] sx, logic signed [15:0] sy,
                                 logic signed [31:0] depth, logic behind);
    projection_t e;
    if (pending.size() == 0) begin
      $error("result with no request outstanding");
      errors++;
      return;
    end
    e = pending.pop_front();
    if (sx !== e.sx) begin
      $error("pix_x expected %0d got %0d", e.sx, sx); errors++;
    end
    if (sy !== e.sy) begin
      $error("pix_y expected %0d got %0d", e.sy, sy); errors++;
    end
    if (depth !== e.depth) begin
      $error("depth expected %0d got %0d", e.depth, depth); errors++;
    end
    if (behind !== e.behind) begin
      $error("behind_camera expected %0b got %0b", e.behind, behind); errors++;
    end
  endfunction
endclass

module tb_top;
  import pvp_pkg::*;

  localparam int LATENCY   = 71;
  localparam int WATCHDOG  = 2000;
  localparam int N_RANDOM  = 1400;
  localparam logic [2:0] REG_UNUSED = 3'd7;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [31:0] vx_i = '0, vy_i = '0, vz_i = '0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [2:0] cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic done_o;
  logic signed [15:0] pix_x_o, pix_y_o;
  logic signed [31:0] depth_o;
  logic behind_camera_o;

  projection_scoreboard sb = new();
  int idle_cycles = 0;
  bit no_gaps = 1'b0;

  perspective_vertex_projector_core dut (
    .clk_i, .rst_ni, .start, .busy, .vx_i, .vy_i, .vz_i,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .done_o, .pix_x_o, .pix_y_o, .depth_o, .behind_camera_o
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Sample results at the rising edge; the receiver never stalls.
  always @(posedge clk_i) begin
    if (rst_ni && done_o)
      sb.check_projection(pix_x_o, pix_y_o, depth_o, behind_camera_o);
  end

  // Watchdog: count cycles in which no request, register write or result moves.
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o || (cfg_valid_i && cfg_ready_o))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG) begin
      $display("** perspective_vertex_projector_core: FAILED **");
      $finish;
    end
  end

  // Hold start high with the vertex until the core takes it.
  task automatic send_vertex(logic signed [31:0] x, logic signed [31:0] y,
                             logic signed [31:0] z);
    vx_i <= x; vy_i <= y; vz_i <= z;
    start <= 1'b1;
    do @(posedge clk_i); while (busy);
    sb.note_vertex(x, y, z);
    @(negedge clk_i);
    // drop start only when a gap follows, never lower and raise it again
    if (!no_gaps && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
  endtask

  // Drop valid for one cycle after each write so the next write starts later.
  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    cfg_index_i <= idx; cfg_data_i <= data; cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Lower start and let the pipeline empty before touching registers.
  task automatic drain();
    start <= 1'b0;
    @(negedge clk_i);
    while (sb.pending.size() != 0) @(negedge clk_i);
  endtask

  function automatic logic [15:0] rand_trig();
    case ($urandom_range(0, 4))
      0: return 16'h4000;
      1: return 16'hC000;
      2: return 16'h0000;
      3: return 16'($urandom_range(0, 16'h8000) - 16'h4000);
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom();
      default: return $urandom_range(0, 32'h0400_0000) - 32'h0200_0000;
    endcase
  endfunction

  task automatic random_settings(bit extreme);
    if (extreme) begin
      write_reg(REG_ROT_Z, 32'h8000_8000);
      write_reg(REG_ROT_X, 32'h7FFF_7FFF);
      write_reg(REG_FOV, 32'hFFFF_FFFF);
      write_reg(REG_ORG_X, 32'h7FFF_FFFF);
      write_reg(REG_ORG_Y, 32'h0);
      write_reg(REG_OFS_X, 32'h7FFF);
      write_reg(REG_OFS_Y, 32'h8000);
    end else begin
      write_reg(REG_ROT_Z, {rand_trig(), rand_trig()});
      write_reg(REG_ROT_X, {rand_trig(), rand_trig()});
      write_reg(REG_FOV, $urandom_range(0, 3) == 0 ? $urandom()
                                                   : $urandom_range(0, 32'h0200_0000));
      write_reg(REG_ORG_X, $urandom());
      write_reg(REG_ORG_Y, $urandom_range(0, 32'h0400_0000));
      write_reg(REG_OFS_X, $urandom());
      write_reg(REG_OFS_Y, $urandom_range(0, 200) - 100);
    end
    // an unknown index must be ignored
    write_reg(REG_UNUSED, $urandom());
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: field extremes, on-axis points and a vertex at the camera.
    send_vertex(0, 0, 0);
    send_vertex(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    send_vertex(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
    send_vertex(32'sh0001_0000, -32'sh0001_0000, 29491200);   // depth exactly zero
    send_vertex(0, 0, 29491201);                                // just behind
    send_vertex(0, 0, 29491199);                                // depth one lsb
    send_vertex(32'sh4000_0000, 0, 29491199);                   // screen overflow
    send_vertex(-32'sh4000_0000, 0, 29491199);
    send_vertex(32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA);
    drain();
    random_settings(1'b1);
    send_vertex(32'sh7FFF_FFFF, 32'sh8000_0000, 0);
    send_vertex(32'sh0100_0000, 32'sh0100_0000, 32'sh0100_0000);
    send_vertex(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
    send_vertex(0, 0, 0);
    drain();
    sb.reset_regs();
    write_reg(REG_ROT_Z, 32'h4000); write_reg(REG_ROT_X, 32'h4000);
    write_reg(REG_FOV, 32'h10000);  write_reg(REG_ORG_X, 0);
    write_reg(REG_ORG_Y, 0);        write_reg(REG_OFS_X, 0);
    write_reg(REG_OFS_Y, 0);

    // Random phases with fresh settings each time; the final phase has no gaps.
    for (int ph = 0; ph < 7; ph++) begin
      drain();
      random_settings(ph == 3);
      no_gaps = (ph == 6);
      for (int i = 0; i < N_RANDOM / 7; i++)
        send_vertex(rand_coord(), rand_coord(), rand_coord());
    end
    drain();
    repeat (LATENCY + 10) @(negedge clk_i);

    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("** perspective_vertex_projector_core: PASSED **");
    else
      $display("** perspective_vertex_projector_core: FAILED **");
    $finish;
  end
endmodule

/* perspective_vertex_projector_core.f */
rtl/core/pvp_pkg.sv
rtl/core/pvp_div_pipe.sv
rtl/core/perspective_vertex_projector_core.sv
tb/tb_top.sv
